// File: src/btcsr_pkg.sv
// Shared types and constants for the branch trace and call stack recorder.
`timescale 1ns / 1ps

package btcsr_pkg;

   localparam int ADDR_W = 64;
   localparam int MODE_W = 4;
   localparam int IDX_W  = 4;
   localparam int KIND_W = 3;
   localparam int CNT_W  = 5;

   // Event codes
   localparam logic [MODE_W-1:0] MODE_CALL_START   = 4'd0;
   localparam logic [MODE_W-1:0] MODE_CALL_END     = 4'd1;
   localparam logic [MODE_W-1:0] MODE_CALLEX_START = 4'd2;
   localparam logic [MODE_W-1:0] MODE_CALLEX_END   = 4'd3;
   localparam logic [MODE_W-1:0] MODE_RET_START    = 4'd4;
   localparam logic [MODE_W-1:0] MODE_RET_END      = 4'd5;
   localparam logic [MODE_W-1:0] MODE_JMP_START    = 4'd6;
   localparam logic [MODE_W-1:0] MODE_JMP_END      = 4'd7;
   localparam logic [MODE_W-1:0] MODE_JMP8_START   = 4'd8;
   localparam logic [MODE_W-1:0] MODE_JMP8_END     = 4'd9;
   localparam logic [MODE_W-1:0] MODE_IMAGE_ENTRY  = 4'd10;
   localparam logic [MODE_W-1:0] MODE_INTERP_ENTRY = 4'd11;
   localparam logic [MODE_W-1:0] MODE_READ_TRACE   = 4'd12;
   localparam logic [MODE_W-1:0] MODE_READ_STACK   = 4'd13;

   // Sources pushed by the entry events
   localparam logic [ADDR_W-1:0] SRC_IMAGE_ENTRY  = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [ADDR_W-1:0] SRC_INTERP_ENTRY = 64'hFFFF_FFFF_FFFF_FFFE;

   typedef struct packed {
      logic [ADDR_W-1:0] source;
      logic [ADDR_W-1:0] dest;
      logic [KIND_W-1:0] kind;
   } trace_rec_type;

   typedef struct packed {
      logic [ADDR_W-1:0] source;
      logic [ADDR_W-1:0] dest;
      logic [ADDR_W-1:0] param;
   } stack_rec_type;

   // Controller to datapath
   typedef struct packed {
      logic load;   // latch the accepted request
      logic exec;   // update the buffers and read the addressed record
   } ctl_cmd_type;

endpackage

// File: src/btcsr_ctrl.sv
// Request sequencer: accept, execute, present the response.
`timescale 1ns / 1ps

module btcsr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output btcsr_pkg::ctl_cmd_type cmd
);
   import btcsr_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_RESP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign cmd.load   = req_tready && req_tvalid;
   assign cmd.exec   = (state_ff == S_EXEC);

endmodule

// File: src/btcsr_datapath.sv
// Trace and call stack ring buffers, pending registers and read port.
`timescale 1ns / 1ps

module btcsr_datapath #(
   parameter int TRACE_DEPTH = 16,
   parameter int STACK_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  btcsr_pkg::ctl_cmd_type              cmd,
   input  logic [btcsr_pkg::MODE_W-1:0]        mode,
   input  logic [btcsr_pkg::ADDR_W-1:0]        address,
   input  logic [btcsr_pkg::ADDR_W-1:0]        parameter_address,
   input  logic [btcsr_pkg::IDX_W-1:0]         read_index,
   output logic [btcsr_pkg::CNT_W-1:0]         trace_count,
   output logic [btcsr_pkg::CNT_W-1:0]         stack_depth,
   output logic                                read_valid,
   output logic [btcsr_pkg::ADDR_W-1:0]        read_source,
   output logic [btcsr_pkg::ADDR_W-1:0]        read_dest,
   output logic [btcsr_pkg::KIND_W-1:0]        read_kind,
   output logic [btcsr_pkg::ADDR_W-1:0]        read_parameter
);
   import btcsr_pkg::*;

   localparam int TPW = (TRACE_DEPTH > 1) ? $clog2(TRACE_DEPTH) : 1;
   localparam int SPW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int TFW = $clog2(TRACE_DEPTH + 1);
   localparam int SFW = $clog2(STACK_DEPTH + 1);
   localparam int TIW = (TFW > IDX_W) ? TFW : IDX_W;
   localparam int SIW = (SFW > IDX_W) ? SFW : IDX_W;

   // latched request
   logic [MODE_W-1:0] mode_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [ADDR_W-1:0] param_ff;
   logic [IDX_W-1:0]  idx_ff;

   // ring pointers and fills
   logic [TPW-1:0] trace_head_ff, trace_head_in;
   logic [TFW-1:0] trace_fill_ff, trace_fill_in;
   logic [SPW-1:0] stack_head_ff, stack_head_in;
   logic [SFW-1:0] stack_fill_ff, stack_fill_in;

   // pending start state
   logic [ADDR_W-1:0] tpend_src_ff, tpend_src_in;
   logic [KIND_W-1:0] tpend_kind_ff, tpend_kind_in;
   logic [ADDR_W-1:0] spend_src_ff, spend_src_in;
   logic [ADDR_W-1:0] spend_param_ff, spend_param_in;

   // read result
   logic          rd_valid_ff, rd_valid_in;
   logic          rd_trace_ff;
   trace_rec_type trace_q_ff;
   stack_rec_type stack_q_ff;

   trace_rec_type trace_mem [TRACE_DEPTH];
   stack_rec_type stack_mem [STACK_DEPTH];

   logic          trace_we, stack_we;
   trace_rec_type trace_wr_rec;
   stack_rec_type stack_wr_rec;
   logic [TPW-1:0] trace_wr_addr, trace_rd_addr;
   logic [SPW-1:0] stack_wr_addr, stack_rd_addr;
   logic [TPW:0]   trace_wsum, trace_rsum;
   logic [SPW:0]   stack_wsum, stack_rsum;
   logic           trace_full, stack_full;
   logic           trace_idx_ok, stack_idx_ok;

   assign trace_full = (trace_fill_ff == TFW'(TRACE_DEPTH));
   assign stack_full = (stack_fill_ff == SFW'(STACK_DEPTH));

   // logical slot to physical slot, the write sum stays below twice the depth
   assign trace_wsum = {1'b0, trace_head_ff} + (TPW+1)'(trace_fill_ff);
   assign trace_rsum = {1'b0, trace_head_ff} + (TPW+1)'(idx_ff);
   assign stack_wsum = {1'b0, stack_head_ff} + (SPW+1)'(stack_fill_ff);
   assign stack_rsum = {1'b0, stack_head_ff} + (SPW+1)'(idx_ff);

   always_comb begin
      logic [TPW:0] tw, tr;
      logic [SPW:0] sw, sr;
      tw = (trace_wsum >= (TPW+1)'(TRACE_DEPTH)) ? trace_wsum - (TPW+1)'(TRACE_DEPTH)
                                                 : trace_wsum;
      tr = (trace_rsum >= (TPW+1)'(TRACE_DEPTH)) ? trace_rsum - (TPW+1)'(TRACE_DEPTH)
                                                 : trace_rsum;
      sw = (stack_wsum >= (SPW+1)'(STACK_DEPTH)) ? stack_wsum - (SPW+1)'(STACK_DEPTH)
                                                 : stack_wsum;
      sr = (stack_rsum >= (SPW+1)'(STACK_DEPTH)) ? stack_rsum - (SPW+1)'(STACK_DEPTH)
                                                 : stack_rsum;
      // when full, the new record overwrites the oldest at the head
      trace_wr_addr = trace_full ? trace_head_ff : tw[TPW-1:0];
      stack_wr_addr = stack_full ? stack_head_ff : sw[SPW-1:0];
      trace_rd_addr = tr[TPW-1:0];
      stack_rd_addr = sr[SPW-1:0];
   end

   assign trace_idx_ok = (TIW'(idx_ff) < TIW'(trace_fill_ff));
   assign stack_idx_ok = (SIW'(idx_ff) < SIW'(stack_fill_ff));

   always_comb begin
      trace_head_in  = trace_head_ff;
      trace_fill_in  = trace_fill_ff;
      stack_head_in  = stack_head_ff;
      stack_fill_in  = stack_fill_ff;
      tpend_src_in   = tpend_src_ff;
      tpend_kind_in  = tpend_kind_ff;
      spend_src_in   = spend_src_ff;
      spend_param_in = spend_param_ff;
      trace_we       = 1'b0;
      stack_we       = 1'b0;
      trace_wr_rec   = '{source: tpend_src_ff, dest: addr_ff, kind: tpend_kind_ff};
      stack_wr_rec   = '{source: spend_src_ff, dest: addr_ff, param: spend_param_ff};
      rd_valid_in    = 1'b0;

      if (cmd.exec) begin
         case (mode_ff)
            MODE_CALL_START, MODE_CALLEX_START, MODE_RET_START,
            MODE_JMP_START, MODE_JMP8_START: begin
               tpend_src_in  = addr_ff;
               tpend_kind_in = mode_ff[3:1];
               if (mode_ff == MODE_CALL_START) begin
                  spend_src_in   = addr_ff;
                  spend_param_in = param_ff;
               end
               // pop on an empty stack is ignored
               if (mode_ff == MODE_RET_START && stack_fill_ff != '0) begin
                  stack_fill_in = stack_fill_ff - 1'b1;
               end
            end
            MODE_CALL_END, MODE_CALLEX_END, MODE_RET_END,
            MODE_JMP_END, MODE_JMP8_END: begin
               trace_we = 1'b1;
               if (mode_ff == MODE_CALL_END) stack_we = 1'b1;
            end
            MODE_IMAGE_ENTRY: begin
               stack_we     = 1'b1;
               stack_wr_rec = '{source: SRC_IMAGE_ENTRY, dest: addr_ff, param: param_ff};
            end
            MODE_INTERP_ENTRY: begin
               stack_we     = 1'b1;
               stack_wr_rec = '{source: SRC_INTERP_ENTRY, dest: addr_ff, param: param_ff};
            end
            MODE_READ_TRACE: begin
               rd_valid_in = trace_idx_ok;
            end
            MODE_READ_STACK: begin
               rd_valid_in = stack_idx_ok;
            end
            default: begin
            end
         endcase

         if (trace_we) begin
            if (trace_full) begin
               trace_head_in = (trace_head_ff == TPW'(TRACE_DEPTH - 1)) ? '0
                                                                        : trace_head_ff + 1'b1;
            end else begin
               trace_fill_in = trace_fill_ff + 1'b1;
            end
         end
         if (stack_we) begin
            if (stack_full) begin
               stack_head_in = (stack_head_ff == SPW'(STACK_DEPTH - 1)) ? '0
                                                                        : stack_head_ff + 1'b1;
            end else begin
               stack_fill_in = stack_fill_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trace_head_ff  <= '0;
         trace_fill_ff  <= '0;
         stack_head_ff  <= '0;
         stack_fill_ff  <= '0;
         tpend_src_ff   <= '0;
         tpend_kind_ff  <= '0;
         spend_src_ff   <= '0;
         spend_param_ff <= '0;
         rd_valid_ff    <= 1'b0;
      end else begin
         trace_head_ff  <= trace_head_in;
         trace_fill_ff  <= trace_fill_in;
         stack_head_ff  <= stack_head_in;
         stack_fill_ff  <= stack_fill_in;
         tpend_src_ff   <= tpend_src_in;
         tpend_kind_ff  <= tpend_kind_in;
         spend_src_ff   <= spend_src_in;
         spend_param_ff <= spend_param_in;
         if (cmd.exec) rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= mode;
         addr_ff  <= address;
         param_ff <= parameter_address;
         idx_ff   <= read_index;
      end
      if (cmd.exec) rd_trace_ff <= (mode_ff == MODE_READ_TRACE);
   end

   always_ff @(posedge clock) begin
      if (trace_we) trace_mem[trace_wr_addr] <= trace_wr_rec;
      if (cmd.exec) trace_q_ff <= trace_mem[trace_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (stack_we) stack_mem[stack_wr_addr] <= stack_wr_rec;
      if (cmd.exec) stack_q_ff <= stack_mem[stack_rd_addr];
   end

   assign trace_count    = CNT_W'(trace_fill_ff);
   assign stack_depth    = CNT_W'(stack_fill_ff);
   assign read_valid     = rd_valid_ff;
   assign read_source    = !rd_valid_ff ? '0 : (rd_trace_ff ? trace_q_ff.source
                                                             : stack_q_ff.source);
   assign read_dest      = !rd_valid_ff ? '0 : (rd_trace_ff ? trace_q_ff.dest
                                                             : stack_q_ff.dest);
   assign read_kind      = (rd_valid_ff && rd_trace_ff) ? trace_q_ff.kind : '0;
   assign read_parameter = (rd_valid_ff && !rd_trace_ff) ? stack_q_ff.param : '0;

endmodule

// File: src/branch_trace_and_call_stack_recorder_top.sv
// Top level of the branch trace and call stack recorder.
`timescale 1ns / 1ps
//
// Usage: each request on the req_ channel is one interpreter hook event
// (call, callex, ret, jmp, jmp8 start or end, image entry, interpret entry)
// or a read of a held trace or call stack record by index, oldest first.
// Every request yields exactly one response on the rsp_ channel with the
// trace and stack fill after the event and, for reads, the record fields.
// Both buffers are rings of TRACE_DEPTH / STACK_DEPTH entries; when a ring
// is full the newest record replaces the oldest.
// After a request is accepted the sequencer passes through its execute
// state to its response state. The three-step sequencer (accept, buffer update
// with registered memory read, response) holds one request at a time; the next
// request is taken the cycle after the response is accepted.
// Reset (synchronous) empties both buffers and clears the pending
// start registers; no clearing pass is needed.
// If the receiver holds rsp_tready low, the response is held stable and
// req_tready stays low until it is taken.
//
module branch_trace_and_call_stack_recorder_top #(
   parameter int TRACE_DEPTH = 16,
   parameter int STACK_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // address[63:0], parameter_address[127:64], read_index[131:128], zero pad
   input  logic [135:0] req_tdata,
   // mode[3:0]
   input  logic [3:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // trace_count[4:0], stack_depth[9:5], read_source[73:10],
   // read_dest[137:74], read_parameter[201:138], zero pad
   output logic [207:0] rsp_tdata,
   // read_valid[0], read_kind[3:1]
   output logic [3:0]   rsp_tuser
);
   import btcsr_pkg::*;

   ctl_cmd_type       cmd;
   logic [CNT_W-1:0]  trace_count;
   logic [CNT_W-1:0]  stack_depth;
   logic              read_valid;
   logic [ADDR_W-1:0] read_source;
   logic [ADDR_W-1:0] read_dest;
   logic [KIND_W-1:0] read_kind;
   logic [ADDR_W-1:0] read_parameter;

   btcsr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   btcsr_datapath #(
      .TRACE_DEPTH (TRACE_DEPTH),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .mode              (req_tuser),
      .address           (req_tdata[63:0]),
      .parameter_address (req_tdata[127:64]),
      .read_index        (req_tdata[131:128]),
      .trace_count       (trace_count),
      .stack_depth       (stack_depth),
      .read_valid        (read_valid),
      .read_source       (read_source),
      .read_dest         (read_dest),
      .read_kind         (read_kind),
      .read_parameter    (read_parameter)
   );

   assign rsp_tdata = {6'd0, read_parameter, read_dest, read_source, stack_depth, trace_count};
   assign rsp_tuser = {read_kind, read_valid};

   // the block never takes a request while a response is outstanding
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request accepted while a response is pending");

   // a response follows every accepted request once the execute state is done
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> ##1 rsp_tvalid)
      else $error("response missing two cycles after request");

   // the sequencer executes for exactly one cycle per request
   a_exec_once: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> !cmd.exec)
      else $error("buffer update repeated for one request");

   // outside a valid read all record fields are zero
   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[201:10] == '0 && rsp_tuser[3:1] == '0))
      else $error("record fields nonzero without a valid read");

endmodule

// File: dv/tb.sv
// Self-checking testbench for the branch trace and call stack recorder.
`timescale 1ns / 1ps

module tb;
   import btcsr_pkg::*;

   localparam int TRACE_DEPTH = 16;
   localparam int STACK_DEPTH = 16;
   localparam int HOLD_CYCLES = 400;
   localparam int STALL_LIMIT = 4000;
   localparam int NUM_KINDS   = 5;
   localparam int NUM_DIRECTED = 25;

   localparam logic [MODE_W-1:0] MODE_SPARE_A = 4'd14;
   localparam logic [MODE_W-1:0] MODE_SPARE_B = 4'd15;
   localparam logic [KIND_W-1:0] KIND_CALL    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_RET     = 3'd2;
   localparam logic [ADDR_W-1:0] ADDR_ONES    = '1;

   typedef struct packed {
      logic [CNT_W-1:0]  trace_count;
      logic [CNT_W-1:0]  stack_depth;
      logic              read_valid;
      logic [ADDR_W-1:0] read_source;
      logic [ADDR_W-1:0] read_dest;
      logic [KIND_W-1:0] read_kind;
      logic [ADDR_W-1:0] read_parameter;
   } hook_result_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] param;
      logic [IDX_W-1:0]  idx;
      logic              typed;
      hook_result_type   result;
   } stim_row_type;

   localparam hook_result_type EMPTY_RESULT = '0;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [135:0] req_tdata;
   logic [3:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [207:0] rsp_tdata;
   logic [3:0]   rsp_tuser;

   // typed directed rows carry a hand-written result alongside the request
   logic            row_typed;
   hook_result_type row_result;

   hook_result_type result_q [$];
   int fail_count;
   int sent_count;
   int tx_idle_pct;
   int rx_idle_pct;
   int hold_requests;
   int stall_cycles;

   // predictor state
   logic [ADDR_W-1:0] trc_src [TRACE_DEPTH];
   logic [ADDR_W-1:0] trc_dst [TRACE_DEPTH];
   logic [KIND_W-1:0] trc_kind [TRACE_DEPTH];
   logic [ADDR_W-1:0] pend_src;
   logic [KIND_W-1:0] pend_kind;
   int                trc_fill;
   logic [ADDR_W-1:0] stk_src [STACK_DEPTH];
   logic [ADDR_W-1:0] stk_dst [STACK_DEPTH];
   logic [ADDR_W-1:0] stk_par [STACK_DEPTH];
   logic [ADDR_W-1:0] stk_pend_src;
   logic [ADDR_W-1:0] stk_pend_par;
   int                stk_fill;

   logic [MODE_W-1:0] branch_start_modes [NUM_KINDS];
   logic [MODE_W-1:0] branch_end_modes [NUM_KINDS];
   stim_row_type      directed_rows [NUM_DIRECTED];

   branch_trace_and_call_stack_recorder_top #(
      .TRACE_DEPTH(TRACE_DEPTH),
      .STACK_DEPTH(STACK_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void push_stack_record(logic [ADDR_W-1:0] src, logic [ADDR_W-1:0] dst,
                                             logic [ADDR_W-1:0] par);
      if (stk_fill == STACK_DEPTH) begin
         for (int i = 0; i < STACK_DEPTH - 1; i++) begin
            stk_src[i] = stk_src[i+1];
            stk_dst[i] = stk_dst[i+1];
            stk_par[i] = stk_par[i+1];
         end
         stk_fill--;
      end
      stk_src[stk_fill] = src;
      stk_dst[stk_fill] = dst;
      stk_par[stk_fill] = par;
      stk_fill++;
   endfunction

   function automatic hook_result_type apply_hook_event(logic [MODE_W-1:0] mode,
                                                        logic [ADDR_W-1:0] addr,
                                                        logic [ADDR_W-1:0] param,
                                                        logic [IDX_W-1:0] idx);
      hook_result_type r;
      r = EMPTY_RESULT;
      case (mode)
         MODE_CALL_START, MODE_CALLEX_START, MODE_RET_START, MODE_JMP_START,
         MODE_JMP8_START: begin
            // return start pops the newest call; empty stack is left alone
            if (mode == MODE_RET_START && stk_fill > 0) begin
               stk_fill--;
               stk_src[stk_fill] = '0;
               stk_dst[stk_fill] = '0;
            end
            pend_src  = addr;
            pend_kind = mode[3:1];
            if (mode == MODE_CALL_START) begin
               stk_pend_src = addr;
               stk_pend_par = param;
            end
         end
         MODE_CALL_END, MODE_CALLEX_END, MODE_RET_END, MODE_JMP_END, MODE_JMP8_END: begin
            if (mode == MODE_CALL_END)
               push_stack_record(stk_pend_src, addr, stk_pend_par);
            if (trc_fill == TRACE_DEPTH) begin
               for (int i = 0; i < TRACE_DEPTH - 1; i++) begin
                  trc_src[i]  = trc_src[i+1];
                  trc_dst[i]  = trc_dst[i+1];
                  trc_kind[i] = trc_kind[i+1];
               end
               trc_fill--;
            end
            trc_src[trc_fill]  = pend_src;
            trc_dst[trc_fill]  = addr;
            trc_kind[trc_fill] = pend_kind;
            trc_fill++;
         end
         MODE_IMAGE_ENTRY, MODE_INTERP_ENTRY: begin
            push_stack_record(mode == MODE_IMAGE_ENTRY ? SRC_IMAGE_ENTRY : SRC_INTERP_ENTRY,
                              addr, param);
         end
         MODE_READ_TRACE: begin
            if (idx < trc_fill) begin
               r.read_valid  = 1'b1;
               r.read_source = trc_src[idx];
               r.read_dest   = trc_dst[idx];
               r.read_kind   = trc_kind[idx];
            end
         end
         MODE_READ_STACK: begin
            if (idx < stk_fill) begin
               r.read_valid     = 1'b1;
               r.read_source    = stk_src[idx];
               r.read_dest      = stk_dst[idx];
               r.read_parameter = stk_par[idx];
            end
         end
         default: ;
      endcase
      r.trace_count = CNT_W'(trc_fill);
      r.stack_depth = CNT_W'(stk_fill);
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] random_address();
      case ($urandom_range(7))
         0: return '0;
         1: return ADDR_ONES;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
                              input logic [ADDR_W-1:0] seen);
      if (want !== seen) begin
         $error("%s mismatch: expected %h, got %h", name, want, seen);
         fail_count++;
      end
   endtask

   // compare responses, then predict the request taken at this edge
   always @(posedge clock) begin : scoreboard
      hook_result_type seen;
      hook_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            seen = '{rsp_tdata[4:0], rsp_tdata[9:5], rsp_tuser[0], rsp_tdata[73:10],
                     rsp_tdata[137:74], rsp_tuser[3:1], rsp_tdata[201:138]};
            if (result_q.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               want = result_q.pop_front();
               check_field("trace_count", want.trace_count, seen.trace_count);
               check_field("stack_depth", want.stack_depth, seen.stack_depth);
               check_field("read_valid", want.read_valid, seen.read_valid);
               check_field("read_source", want.read_source, seen.read_source);
               check_field("read_dest", want.read_dest, seen.read_dest);
               check_field("read_kind", want.read_kind, seen.read_kind);
               check_field("read_parameter", want.read_parameter, seen.read_parameter);
            end
         end
         if (req_tvalid && req_tready) begin
            want = apply_hook_event(req_tuser, req_tdata[63:0], req_tdata[127:64],
                                    req_tdata[131:128]);
            result_q.push_back(row_typed ? row_result : want);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : rsp_sink
      int hold_left;
      int holds_served;
      hold_left    = 0;
      holds_served = 0;
      rsp_tready   = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // entered and left at a falling edge; tvalid stays up between back-to-back requests
   task automatic send_request(input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] addr,
                               input logic [ADDR_W-1:0] param, input logic [IDX_W-1:0] idx,
                               input logic typed = 1'b0,
                               input hook_result_type result = EMPTY_RESULT);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {4'b0, idx, param, addr};
      row_typed  <= typed;
      row_result <= result;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      if (mode <= MODE_READ_STACK) sent_count++;
   endtask

   task automatic pause_until_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (result_q.size() != 0) @(negedge clock);
   endtask

   task automatic send_random_events(input int target, input int favored_kind,
                                     input int favor_pct);
      int pick;
      int k;
      while (sent_count < target) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            k = ($urandom_range(99) < favor_pct) ? favored_kind : $urandom_range(NUM_KINDS - 1);
            send_request(branch_start_modes[k], random_address(), random_address(),
                         IDX_W'($urandom_range(15)));
            send_request(branch_end_modes[k], random_address(), random_address(),
                         IDX_W'($urandom_range(15)));
         end else if (pick < 70) begin
            send_request($urandom_range(1) ? MODE_IMAGE_ENTRY : MODE_INTERP_ENTRY,
                         random_address(), random_address(), IDX_W'($urandom_range(15)));
         end else if (pick < 88) begin
            send_request($urandom_range(1) ? MODE_READ_TRACE : MODE_READ_STACK,
                         random_address(), random_address(), IDX_W'($urandom_range(15)));
         end else begin
            // any code at random, including lone starts and ends and spare codes
            send_request(MODE_W'($urandom_range(15)), random_address(), random_address(),
                         IDX_W'($urandom_range(15)));
         end
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = '0;
      row_typed     = 1'b0;
      row_result    = EMPTY_RESULT;
      fail_count    = 0;
      sent_count    = 0;
      tx_idle_pct   = 20;
      rx_idle_pct   = 74;
      hold_requests = 0;
      stall_cycles  = 0;
      trc_fill      = 0;
      stk_fill      = 0;
      pend_src      = '0;
      pend_kind     = '0;
      stk_pend_src  = '0;
      stk_pend_par  = '0;
      for (int i = 0; i < TRACE_DEPTH; i++) begin
         trc_src[i]  = '0;
         trc_dst[i]  = '0;
         trc_kind[i] = '0;
      end
      for (int i = 0; i < STACK_DEPTH; i++) begin
         stk_src[i] = '0;
         stk_dst[i] = '0;
         stk_par[i] = '0;
      end
      branch_start_modes = '{MODE_CALL_START, MODE_CALLEX_START, MODE_RET_START,
                             MODE_JMP_START, MODE_JMP8_START};
      branch_end_modes   = '{MODE_CALL_END, MODE_CALLEX_END, MODE_RET_END,
                             MODE_JMP_END, MODE_JMP8_END};

      // mode, address, parameter, index, typed, result
      directed_rows = '{
         '{MODE_READ_TRACE, 64'h0, 64'h0, 4'd0, 1'b1, EMPTY_RESULT},
         '{MODE_READ_STACK, ADDR_ONES, ADDR_ONES, 4'd15, 1'b1, EMPTY_RESULT},
         '{MODE_RET_START, 64'h0, ADDR_ONES, 4'd15, 1'b1, EMPTY_RESULT},
         '{MODE_RET_END, ADDR_ONES, 64'h0, 4'd0, 1'b1,
           '{5'd1, 5'd0, 1'b0, 64'h0, 64'h0, 3'd0, 64'h0}},
         '{MODE_READ_TRACE, 64'h0, 64'h0, 4'd0, 1'b1,
           '{5'd1, 5'd0, 1'b1, 64'h0, ADDR_ONES, KIND_RET, 64'h0}},
         '{MODE_READ_TRACE, 64'h0, 64'h0, 4'd1, 1'b1,
           '{5'd1, 5'd0, 1'b0, 64'h0, 64'h0, 3'd0, 64'h0}},
         '{MODE_CALL_START, ADDR_ONES, 64'h5555_5555_5555_5555, 4'd0, 1'b0, EMPTY_RESULT},
         '{MODE_CALL_END, 64'h0123_4567_89AB_CDEF, 64'h0, 4'd0, 1'b0, EMPTY_RESULT},
         '{MODE_READ_STACK, 64'h0, 64'h0, 4'd0, 1'b0, EMPTY_RESULT},
         '{MODE_CALLEX_START, 64'h8000_0000_0000_0000, 64'h1, 4'd5, 1'b0, EMPTY_RESULT},
         '{MODE_CALLEX_END, 64'h7FFF_FFFF_FFFF_FFFF, 64'h2, 4'd10, 1'b0, EMPTY_RESULT},
         '{MODE_JMP_START, 64'hAAAA_AAAA_AAAA_AAAA, 64'h0, 4'd0, 1'b0, EMPTY_RESULT},
         '{MODE_JMP_END, 64'h5555_5555_5555_5555, 64'h0, 4'd0, 1'b0, EMPTY_RESULT},
         '{MODE_JMP8_START, 64'h0000_0000_FFFF_FFFF, 64'h0, 4'd0, 1'b0, EMPTY_RESULT},
         '{MODE_JMP8_END, 64'hFFFF_FFFF_0000_0000, 64'h0, 4'd0, 1'b0, EMPTY_RESULT},
         // a second end reuses the held start
         '{MODE_JMP8_END, 64'h1234_0000_0000_5678, 64'h0, 4'd0, 1'b0, EMPTY_RESULT},
         '{MODE_IMAGE_ENTRY, 64'h0, ADDR_ONES, 4'd0, 1'b0, EMPTY_RESULT},
         '{MODE_INTERP_ENTRY, ADDR_ONES, 64'h0, 4'd0, 1'b0, EMPTY_RESULT},
         '{MODE_READ_STACK, 64'h0, 64'h0, 4'd1, 1'b0, EMPTY_RESULT},
         '{MODE_READ_STACK, 64'h0, 64'h0, 4'd2, 1'b0, EMPTY_RESULT},
         '{MODE_RET_START, 64'hDEAD_BEEF_0000_0001, 64'h0, 4'd0, 1'b0, EMPTY_RESULT},
         '{MODE_READ_STACK, 64'h0, 64'h0, 4'd2, 1'b0, EMPTY_RESULT},
         '{MODE_SPARE_A, ADDR_ONES, ADDR_ONES, 4'd0, 1'b0, EMPTY_RESULT},
         '{MODE_SPARE_B, 64'h0, 64'h0, 4'd3, 1'b0, EMPTY_RESULT},
         '{MODE_READ_TRACE, ADDR_ONES, ADDR_ONES, 4'd15, 1'b0, EMPTY_RESULT}
      };

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         send_request(directed_rows[i].mode, directed_rows[i].addr, directed_rows[i].param,
                      directed_rows[i].idx, directed_rows[i].typed, directed_rows[i].result);

      // call-heavy traffic fills the stack; the sink holds off midway
      send_random_events(150, KIND_CALL, 40);
      hold_requests++;
      send_random_events(300, KIND_CALL, 40);
      pause_until_drained();

      tx_idle_pct = 74;
      rx_idle_pct = 20;
      // return-heavy traffic drains the stack into empty pops
      send_random_events(580, KIND_RET, 50);
      pause_until_drained();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      send_random_events(860, KIND_CALL, 0);
      pause_until_drained();
      repeat (10) @(posedge clock);

      if (fail_count == 0 && result_q.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
